/* hdl/mrle_pkg.sv */
package mrle_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned CountW  = 4;
  localparam int unsigned ByteW   = 8;

  localparam logic [CountW-1:0] RunMax = 4'd15;

  localparam logic [CharW-1:0] ChUpLower    = 8'h75;  // u
  localparam logic [CharW-1:0] ChLeftLower  = 8'h6C;  // l
  localparam logic [CharW-1:0] ChDownLower  = 8'h64;  // d
  localparam logic [CharW-1:0] ChRightLower = 8'h72;  // r
  localparam logic [CharW-1:0] ChUpUpper    = 8'h55;  // U
  localparam logic [CharW-1:0] ChLeftUpper  = 8'h4C;  // L
  localparam logic [CharW-1:0] ChDownUpper  = 8'h44;  // D
  localparam logic [CharW-1:0] ChRightUpper = 8'h52;  // R

  typedef enum logic [CodeW-1:0] {
    MoveUpLower    = 3'd0,
    MoveLeftLower  = 3'd1,
    MoveDownLower  = 3'd2,
    MoveRightLower = 3'd3,
    MoveUpUpper    = 3'd4,
    MoveLeftUpper  = 3'd5,
    MoveDownUpper  = 3'd6,
    MoveRightUpper = 3'd7
  } move_code_e;

  typedef struct packed {
    logic       is_move;
    move_code_e code;
  } move_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] packed_byte;
    logic             byte_valid;
    logic             end_of_string;
  } result_t;

endpackage

/* hdl/mrle_decode.sv */
module mrle_decode (
  input  logic [mrle_pkg::CharW-1:0] char_i,
  output mrle_pkg::move_t            move_o
);
  import mrle_pkg::*;

  always_comb begin
    move_o.is_move = 1'b1;
    move_o.code    = MoveUpLower;
    unique case (char_i)
      ChUpLower:    move_o.code = MoveUpLower;
      ChLeftLower:  move_o.code = MoveLeftLower;
      ChDownLower:  move_o.code = MoveDownLower;
      ChRightLower: move_o.code = MoveRightLower;
      ChUpUpper:    move_o.code = MoveUpUpper;
      ChLeftUpper:  move_o.code = MoveLeftUpper;
      ChDownUpper:  move_o.code = MoveDownUpper;
      ChRightUpper: move_o.code = MoveRightUpper;
      default:      move_o.is_move = 1'b0;
    endcase
  end

endmodule

/* hdl/mrle_core.sv */
module mrle_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  mrle_pkg::move_t   move_i,
  output mrle_pkg::result_t res_o
);
  import mrle_pkg::*;

  move_code_e        run_code_q, run_code_d;
  logic [CountW-1:0] run_length_q, run_length_d;
  logic              pending;
  logic [ByteW-1:0]  pending_byte;

  assign pending      = (run_length_q != '0);
  assign pending_byte = {run_length_q, 1'b0, run_code_q};

  always_comb begin
    run_code_d        = run_code_q;
    run_length_d      = run_length_q;
    res_o.valid         = 1'b0;
    res_o.packed_byte   = pending ? pending_byte : '0;
    res_o.byte_valid    = pending;
    res_o.end_of_string = 1'b0;
    priority if (!move_i.is_move) begin
      // terminator flushes the pending run
      res_o.valid         = 1'b1;
      res_o.end_of_string = 1'b1;
      run_code_d          = MoveUpLower;
      run_length_d        = '0;
    end else if (pending && move_i.code == run_code_q && run_length_q != RunMax) begin
      run_length_d = run_length_q + CountW'(1);
    end else begin
      res_o.valid  = pending;
      run_code_d   = move_i.code;
      run_length_d = CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_code_q   <= MoveUpLower;
      run_length_q <= '0;
    end else if (step_i) begin
      run_code_q   <= run_code_d;
      run_length_q <= run_length_d;
    end
  end

endmodule

/* hdl/mrle_out_reg.sv */
module mrle_out_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  mrle_pkg::result_t            res_i,
  output logic                         free_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mrle_pkg::ByteW-1:0]   packed_byte_o,
  output logic                         byte_valid_o,
  output logic                         end_of_string_o
);
  import mrle_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             bvalid_q;
  logic             eos_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i && res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_i.valid) begin
      byte_q   <= res_i.packed_byte;
      bvalid_q <= res_i.byte_valid;
      eos_q    <= res_i.end_of_string;
    end
  end

  assign out_valid_o     = valid_q;
  assign packed_byte_o   = byte_q;
  assign byte_valid_o    = bvalid_q;
  assign end_of_string_o = eos_q;

endmodule

/* hdl/move_run_length_encoder.sv */
// channel  | valid / ready               | payload
// input    | in_valid_i / in_ready_o     | char_in_i
// output   | out_valid_o / out_ready_i   | packed_byte_o, byte_valid_o, end_of_string_o
//
// one character per cycle while the output register is free; a character waits in the input register,
// the run logic then writes at most one item into the output register.
// a result passes the input register and then the output register before it is visible
// rst_ni clears the pending run and both valid flags.
// a full output slot that is not being drained holds the input register, item or not
module move_run_length_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mrle_pkg::CharW-1:0]   char_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mrle_pkg::ByteW-1:0]   packed_byte_o,
  output logic                         byte_valid_o,
  output logic                         end_of_string_o
);
  import mrle_pkg::*;

  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  move_t            move;
  result_t          res;
  logic             out_free;
  logic             step;

  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
    end
  end

  mrle_decode u_decode (
    .char_i (char_q),
    .move_o (move)
  );

  mrle_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .move_i (move),
    .res_o  (res)
  );

  mrle_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step),
    .res_i           (res),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .packed_byte_o   (packed_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_string_o (end_of_string_o)
  );

endmodule
